### hw/rtl/rledd_pkg.sv
// ----------------------------------------------------------------------------
// rledd_pkg: shared types, constants and the RLE decode step
// Holds the command and register codes, the byte-history encoding and the
// single-byte decode function used by the decode unit.
// ----------------------------------------------------------------------------
package rledd_pkg;

	localparam int TILE_MEM_BITS_DEF = 24;
	localparam int ADDR_W            = 24;
	localparam int OFFSET_W          = 21;
	localparam int BANK_W            = 6;
	localparam int LENGTH_W          = 18;
	localparam int CFG_DATA_W        = 18;
	localparam int BANK_SHIFT        = 18;
	localparam int DICT_AW           = 8;
	localparam int PAIR_W            = 16;

	localparam logic [3:0] BITS_PER_GROUP = 4'd8;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_START  = 2'd1,
		CMD_STREAM = 2'd2
	} cmd_t;

	typedef enum logic [0:0] {
		REG_DEST_BANK   = 1'b0,
		REG_LENGTH_CODE = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'b01,
		PH_SECOND = 2'b10
	} phase_t;

	// History entry: either a plain byte, or one of the two start markers
	// 0xfffe and 0xffff (special set, low byte kept so equality is a compare).
	typedef struct packed {
		logic       special;
		logic [7:0] val;
	} hist_t;

	localparam hist_t HIST_PREV_START  = '{special: 1'b1, val: 8'hFE};
	localparam hist_t HIST_PREV2_START = '{special: 1'b1, val: 8'hFF};

	typedef struct packed {
		hist_t      prev;
		hist_t      prev2;
		logic [7:0] value;
		logic [7:0] count;
	} step_t;

	// Everything the decode unit reports for one data byte.
	typedef struct packed {
		logic [ADDR_W-1:0]   addr_a;
		logic [7:0]          value_a;
		logic [7:0]          count_a;
		logic [ADDR_W-1:0]   addr_b;
		logic [7:0]          value_b;
		logic [7:0]          count_b;
		hist_t               prev;
		hist_t               prev2;
		logic [OFFSET_W-1:0] offset;
		logic                done;
	} dec_t;

	// Once the last two written bytes match, the byte is a repeat count.
	function automatic step_t decode_step(hist_t prev, hist_t prev2, logic [7:0] b);
		step_t r;
		if (prev == prev2) begin
			r.prev  = prev;
			r.prev2 = HIST_PREV2_START;
			r.value = prev.val;
			r.count = 8'(b + 8'd1);
		end else begin
			r.prev  = '{special: 1'b0, val: b};
			r.prev2 = prev;
			r.value = b;
			r.count = 8'd1;
		end
		return r;
	endfunction

endpackage

### hw/rtl/rle_dictionary_dma_decoder_top.sv
// ----------------------------------------------------------------------------
// rle_dictionary_dma_decoder_top: byte-pair dictionary RLE decompressor
// Turns a compressed tile stream into write-run descriptors.
// ----------------------------------------------------------------------------
// A data byte's dictionary entry is read as the item is accepted, and decode
// fills the output register from stage 1. Throughput: one item per cycle for
// loads, starts and control bytes, and for literal bytes while the output is
// not stalled; a dictionary byte holds stage 1 until both of its descriptors
// have gone through the single output register. Reset is asynchronous and
// clears all control state; the dictionary is not cleared.
module rle_dictionary_dma_decoder_top import rledd_pkg::*; #(
	parameter int TILE_MEMORY_BITS = TILE_MEM_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port
	input  logic                  cfg_write,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Input channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            command,
	input  logic [DICT_AW-1:0]    dict_index,
	input  logic [PAIR_W-1:0]     dict_pair,
	input  logic [7:0]            stream_byte,
	// Output channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ADDR_W-1:0]     write_address,
	output logic [7:0]            write_value,
	output logic [7:0]            write_count,
	output logic                  item_last,
	output logic                  transfer_done
);

	// Configuration registers. They are live: a change is seen by the very
	// next decode.
	logic [BANK_W-1:0]   bank_q;
	logic [LENGTH_W-1:0] lcode_q;

	// Decoder state.
	hist_t               prev_q;
	hist_t               prev2_q;
	logic [7:0]          ctrl_q;
	logic [3:0]          bits_q;
	logic [OFFSET_W-1:0] off_q;
	logic                finished_q;
	phase_t              phase_q;

	// Stage 1 holds the accepted item while the dictionary read completes.
	logic                valid_s1;
	logic [1:0]          cmd_s1;
	logic [7:0]          byte_s1;

	// Second descriptor of a dictionary byte, waiting for the output port.
	logic [ADDR_W-1:0]   addr2_q;
	logic [7:0]          value2_q;
	logic [7:0]          count2_q;
	logic                done2_q;

	// Output register.
	logic                out_valid_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [7:0]          value_q;
	logic [7:0]          count_q;
	logic                last_q;
	logic                done_q;

	logic                accept;
	logic [PAIR_W-1:0]   pair_rd;
	dec_t                dec;
	logic                is_start;
	logic                is_stream;
	logic                is_ctrl;
	logic                is_data;
	logic                is_pair;
	logic                out_free;
	logic                first_emit;
	logic                second_emit;
	logic                advance;

	assign accept = in_valid && in_ready;

	// Loads write the dictionary as they are accepted. A stream byte reads its
	// entry at acceptance, so a load just ahead of it is already visible and a
	// load just behind it cannot disturb the read.
	rledd_dict u_dict (
		.clk   (clk),
		.we    (accept && (command == CMD_LOAD)),
		.waddr (dict_index),
		.wdata (dict_pair),
		.re    (accept && (command == CMD_STREAM)),
		.raddr (stream_byte),
		.rdata (pair_rd)
	);

	rledd_decode #(
		.TILE_MEMORY_BITS (TILE_MEMORY_BITS)
	) u_decode (
		.prev        (prev_q),
		.prev2       (prev2_q),
		.offset      (off_q),
		.is_pair     (is_pair),
		.literal     (byte_s1),
		.pair        (pair_rd),
		.dest_bank   (bank_q),
		.length_code (lcode_q),
		.dec         (dec)
	);

	// Classification of the item in stage 1. These are only meaningful in the
	// first phase; in the second phase the state has already moved on.
	assign is_start  = valid_s1 && (cmd_s1 == CMD_START) && (phase_q == PH_FIRST);
	assign is_stream = valid_s1 && (cmd_s1 == CMD_STREAM) && !finished_q
		&& (phase_q == PH_FIRST);
	assign is_ctrl   = is_stream && (bits_q == '0);
	assign is_data   = is_stream && (bits_q != '0);
	assign is_pair   = ctrl_q[7];
	assign out_free  = !out_valid_q || out_ready;

	assign first_emit  = is_data && out_free;
	assign second_emit = (phase_q == PH_SECOND) && out_free;

	// An item leaves stage 1 when its last descriptor goes to the output
	// register, or at once if it produces none.
	always_comb begin
		if (phase_q == PH_SECOND) begin
			advance = out_free;
		end else begin
			advance = valid_s1 && (!is_data || (out_free && !is_pair));
		end
	end

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q  <= '0;
			lcode_q <= '0;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_DEST_BANK:   bank_q  <= cfg_data[BANK_W-1:0];
				REG_LENGTH_CODE: lcode_q <= cfg_data[LENGTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= command;
			byte_s1 <= stream_byte;
		end
	end

	// Decoder state update: start resets the history, a control byte loads
	// the bit register, a data byte commits its one or two decode steps at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= HIST_PREV_START;
			prev2_q    <= HIST_PREV2_START;
			ctrl_q     <= '0;
			bits_q     <= '0;
			off_q      <= '0;
			finished_q <= 1'b1;
		end else if (is_start) begin
			prev_q     <= HIST_PREV_START;
			prev2_q    <= HIST_PREV2_START;
			ctrl_q     <= '0;
			bits_q     <= '0;
			off_q      <= '0;
			finished_q <= 1'b0;
		end else if (is_ctrl) begin
			ctrl_q <= byte_s1;
			bits_q <= BITS_PER_GROUP;
		end else if (first_emit) begin
			prev_q     <= dec.prev;
			prev2_q    <= dec.prev2;
			off_q      <= dec.offset;
			ctrl_q     <= {ctrl_q[6:0], 1'b0};
			bits_q     <= 4'(bits_q - 4'd1);
			finished_q <= dec.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
		end else begin
			case (phase_q)
				PH_FIRST: begin
					if (first_emit && is_pair) begin
						phase_q <= PH_SECOND;
					end
				end
				PH_SECOND: begin
					if (second_emit) begin
						phase_q <= PH_FIRST;
					end
				end
				default: phase_q <= PH_FIRST;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (first_emit) begin
			addr2_q  <= dec.addr_b;
			value2_q <= dec.value_b;
			count2_q <= dec.count_b;
			done2_q  <= dec.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (first_emit || second_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (first_emit) begin
			addr_q  <= dec.addr_a;
			value_q <= dec.value_a;
			count_q <= dec.count_a;
			last_q  <= !is_pair;
			done_q  <= dec.done;
		end else if (second_emit) begin
			addr_q  <= addr2_q;
			value_q <= value2_q;
			count_q <= count2_q;
			last_q  <= 1'b1;
			done_q  <= done2_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign write_address = addr_q;
	assign write_value   = value_q;
	assign write_count   = count_q;
	assign item_last     = last_q;
	assign transfer_done = done_q;

	// The second phase always belongs to an item still held in stage 1.
	a_second_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SECOND) |-> valid_s1)
		else $error("second phase without an item in stage 1");

	// No new item may enter while the second descriptor is blocked.
	a_no_accept_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		((phase_q == PH_SECOND) && out_valid_q && !out_ready) |-> !in_ready)
		else $error("input accepted while second descriptor is blocked");

	// A dictionary byte's first descriptor is followed by its second phase.
	a_pair_second: assert property (@(posedge clk) disable iff (!arst_n)
		(first_emit && is_pair) |=> ((phase_q == PH_SECOND) && out_valid_q && !last_q))
		else $error("first descriptor of a pair not followed by second phase");

	// The group bit counter never exceeds one group.
	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= BITS_PER_GROUP)
		else $error("control bit counter out of range");

endmodule

### hw/rtl/rledd_dict.sv
// ----------------------------------------------------------------------------
// rledd_dict: byte-pair dictionary memory
// 256 x 16 single-port-per-direction RAM with a registered read port.
// ----------------------------------------------------------------------------
module rledd_dict import rledd_pkg::*; (
	input  logic               clk,
	input  logic               we,
	input  logic [DICT_AW-1:0] waddr,
	input  logic [PAIR_W-1:0]  wdata,
	input  logic               re,
	input  logic [DICT_AW-1:0] raddr,
	output logic [PAIR_W-1:0]  rdata
);

	logic [PAIR_W-1:0] mem [(1 << DICT_AW)];
	logic [PAIR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/rledd_decode.sv
// ----------------------------------------------------------------------------
// rledd_decode: decode unit for one data byte
// Runs one or two RLE decode steps, advances the output offset and forms
// the tile addresses and the end-of-transfer flag.
// ----------------------------------------------------------------------------
module rledd_decode import rledd_pkg::*; #(
	parameter int TILE_MEMORY_BITS = TILE_MEM_BITS_DEF
) (
	input  hist_t               prev,
	input  hist_t               prev2,
	input  logic [OFFSET_W-1:0] offset,
	input  logic                is_pair,
	input  logic [7:0]          literal,
	input  logic [PAIR_W-1:0]   pair,
	input  logic [BANK_W-1:0]   dest_bank,
	input  logic [LENGTH_W-1:0] length_code,
	output dec_t                dec
);

	localparam logic [ADDR_W-1:0] AddrMask = (TILE_MEMORY_BITS >= ADDR_W) ?
		{ADDR_W{1'b1}} : ADDR_W'((64'd1 << TILE_MEMORY_BITS) - 64'd1);

	step_t               st_a;
	step_t               st_b;
	logic [OFFSET_W-1:0] off_a;
	logic [OFFSET_W-1:0] off_b;
	logic [OFFSET_W-1:0] off_end;
	logic [LENGTH_W:0]   len_words;
	logic [OFFSET_W-1:0] len_bytes;
	logic [ADDR_W-1:0]   base;

	always_comb begin
		st_a = decode_step(prev, prev2, is_pair ? pair[15:8] : literal);
		st_b = decode_step(st_a.prev, st_a.prev2, pair[7:0]);
	end

	assign off_a   = offset + OFFSET_W'(st_a.count);
	assign off_b   = off_a + OFFSET_W'(st_b.count);
	assign off_end = is_pair ? off_b : off_a;

	assign len_words = {1'b0, length_code} + (LENGTH_W+1)'(1);
	assign len_bytes = {len_words, 2'b00};

	assign base = {dest_bank, {BANK_SHIFT{1'b0}}};

	always_comb begin
		dec.addr_a  = (base + ADDR_W'(offset)) & AddrMask;
		dec.value_a = st_a.value;
		dec.count_a = st_a.count;
		dec.addr_b  = (base + ADDR_W'(off_a)) & AddrMask;
		dec.value_b = st_b.value;
		dec.count_b = st_b.count;
		dec.prev    = is_pair ? st_b.prev  : st_a.prev;
		dec.prev2   = is_pair ? st_b.prev2 : st_a.prev2;
		dec.offset  = off_end;
		dec.done    = (off_end >= len_bytes);
	end

endmodule

### verif/tb_rle_dictionary_dma_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_rle_dictionary_dma_decoder_top: self-checking bench for the RLE decoder
// Feeds dictionary loads, transfer starts and compressed stream bytes over the
// input handshake. Every write run that comes out is checked against a
// cycle-free predictor of the decompressor. A short hand-written table comes
// first, followed by randomized transfers under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_rle_dictionary_dma_decoder_top import rledd_pkg::*; ();

	// Command 3 has no meaning for the block; it must be dropped silently.
	localparam logic [1:0]  CMD_IGNORED  = 2'd3;
	localparam logic [15:0] LAST_AT_START  = 16'hFFFE;
	localparam logic [15:0] PRIOR_AT_START = 16'hFFFF;
	localparam logic [31:0] BANK_STRIDE  = 32'h0004_0000;
	localparam int TILE_BITS    = TILE_MEM_BITS_DEF;
	localparam int ITEM_GOAL    = 500;
	localparam int PRESSURE_AT  = 200;
	localparam int CALM_ITEMS   = 80;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 4;
	localparam int QUIET_LIMIT  = 2000;
	localparam int PRINT_LIMIT  = 40;

	// One write run as the block reports it.
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [7:0]        value;
		logic [7:0]        count;
		logic              last;
		logic              done;
	} run_t;

	// One row of the hand-written stimulus table. A row is either a register
	// setting or an item; typed rows carry their expected result (or none).
	typedef struct packed {
		logic        is_regs;
		logic [1:0]  cmd;
		logic [7:0]  idx;
		logic [15:0] pair;
		logic [7:0]  sb;
		logic        typed;
		logic        has_run;
		run_t        run;
		logic [5:0]  bank;
		logic [17:0] len;
	} plan_row_t;

	// The clock toggles every half period; reset is low from time zero.
	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	always #10 clk = ~clk;

	// Every block input starts at a known value.
	logic                  cfg_write   = 1'b0;
	logic [0:0]            cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic [1:0]            command     = '0;
	logic [DICT_AW-1:0]    dict_index  = '0;
	logic [PAIR_W-1:0]     dict_pair   = '0;
	logic [7:0]            stream_byte = '0;
	logic                  out_ready   = 1'b0;
	logic                  in_ready;
	logic                  out_valid;
	logic [ADDR_W-1:0]     write_address;
	logic [7:0]            write_value;
	logic [7:0]            write_count;
	logic                  item_last;
	logic                  transfer_done;

	rle_dictionary_dma_decoder_top #(.TILE_MEMORY_BITS(TILE_BITS)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.dict_index    (dict_index),
		.dict_pair     (dict_pair),
		.stream_byte   (stream_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_address (write_address),
		.write_value   (write_value),
		.write_count   (write_count),
		.item_last     (item_last),
		.transfer_done (transfer_done)
	);

	// ------------------------------------------------------------------
	// Predictor state: the decompressor as seen by a software user.
	// ------------------------------------------------------------------
	logic [15:0] pair_tab [256];
	logic        pair_set [256];
	logic [7:0]  loaded_q [$];
	logic [15:0] hist_last  = LAST_AT_START;
	logic [15:0] hist_prior = PRIOR_AT_START;
	logic [7:0]  ctl_shift  = '0;
	logic [3:0]  ctl_count  = '0;
	logic [OFFSET_W-1:0] run_offset = '0;
	logic        xfer_idle  = 1'b1;
	logic [5:0]  bank_reg   = '0;
	logic [17:0] len_reg    = '0;
	run_t        step_res [2];

	run_t      runs_due [$];
	plan_row_t plan_q [$];

	int items_fed     = 0;
	int items_ignored = 0;
	int runs_checked  = 0;
	int settings_used = 0;
	int mismatches    = 0;
	bit calm          = 1'b0;
	bit hold_req      = 1'b0;
	bit hold_done     = 1'b0;

	// Decodes one byte against the history of the last two written bytes and
	// advances the output offset. Once two equal bytes have been written in a
	// row, the byte is a repeat count for the last one instead of a literal.
	function automatic run_t decode_one(logic [7:0] b);
		run_t        r;
		logic [31:0] full;
		full = 32'(bank_reg) * BANK_STRIDE + 32'(run_offset);
		full = full & ((32'd1 << TILE_BITS) - 32'd1);
		r = '0;
		r.addr = full[ADDR_W-1:0];
		if (hist_last == hist_prior) begin
			r.value = hist_last[7:0];
			r.count = 8'(b + 8'd1);
			hist_prior = PRIOR_AT_START;
		end else begin
			hist_prior = hist_last;
			hist_last = {8'h00, b};
			r.value = b;
			r.count = 8'd1;
		end
		run_offset = run_offset + OFFSET_W'(r.count);
		return r;
	endfunction

	// Applies one accepted item to the predictor; the runs it causes are left
	// in step_res and their number is returned.
	function automatic int apply_item(logic [1:0] cmd, logic [7:0] idx, logic [15:0] pair,
			logic [7:0] sb);
		int          n;
		logic [15:0] p;
		n = 0;
		if (cmd == CMD_LOAD) begin
			pair_tab[idx] = pair;
			if (!pair_set[idx]) begin
				pair_set[idx] = 1'b1;
				loaded_q.push_back(idx);
			end
		end else if (cmd == CMD_START) begin
			hist_last = LAST_AT_START;
			hist_prior = PRIOR_AT_START;
			ctl_shift = '0;
			ctl_count = '0;
			run_offset = '0;
			xfer_idle = 1'b0;
		end else if (cmd == CMD_STREAM && !xfer_idle) begin
			if (ctl_count == 0) begin
				ctl_shift = sb;
				ctl_count = BITS_PER_GROUP;
			end else begin
				if (ctl_shift[7]) begin
					p = pair_tab[sb];
					step_res[0] = decode_one(p[15:8]);
					step_res[1] = decode_one(p[7:0]);
					n = 2;
				end else begin
					step_res[0] = decode_one(sb);
					n = 1;
				end
				ctl_shift = ctl_shift << 1;
				ctl_count = ctl_count - 4'd1;
				// The length registers are live, so the end test uses their
				// current values.
				if (int'(run_offset) >= 4 * (int'(len_reg) + 1))
					xfer_idle = 1'b1;
				for (int i = 0; i < n; i++)
					step_res[i].done = xfer_idle;
				step_res[n-1].last = 1'b1;
			end
		end
		return n;
	endfunction

	// Chooses a stream byte that fits the decoder's current position. A byte
	// that will be used as a dictionary index always names a loaded entry.
	function automatic logic [7:0] pick_stream_byte();
		if (xfer_idle || ctl_count == 0)
			return 8'($urandom);
		if (ctl_shift[7])
			return loaded_q[$urandom_range(0, loaded_q.size() - 1)];
		if (hist_last == hist_prior)
			return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
		if ($urandom_range(0, 2) == 0)
			return hist_last[7:0];
		return 8'($urandom);
	endfunction

	// ------------------------------------------------------------------
	// Table builders for the directed part.
	// ------------------------------------------------------------------
	function automatic void plan_regs(logic [5:0] bank, logic [17:0] len);
		plan_row_t r;
		r = '0;
		r.is_regs = 1'b1;
		r.bank = bank;
		r.len = len;
		plan_q.push_back(r);
	endfunction

	// An item that must produce no write run at all.
	function automatic void plan_quiet(logic [1:0] cmd, logic [7:0] idx, logic [15:0] pair,
			logic [7:0] sb);
		plan_row_t r;
		r = '0;
		r.cmd = cmd;
		r.idx = idx;
		r.pair = pair;
		r.sb = sb;
		r.typed = 1'b1;
		plan_q.push_back(r);
	endfunction

	// A stream byte with exactly one write run, written out by hand.
	function automatic void plan_run(logic [7:0] sb, logic [ADDR_W-1:0] addr, logic [7:0] value,
			logic [7:0] count, logic done);
		plan_row_t r;
		r = '0;
		r.cmd = CMD_STREAM;
		r.sb = sb;
		r.typed = 1'b1;
		r.has_run = 1'b1;
		r.run = '{addr: addr, value: value, count: count, last: 1'b1, done: done};
		plan_q.push_back(r);
	endfunction

	// A stream byte whose runs are left to the predictor.
	function automatic void plan_model(logic [7:0] sb);
		plan_row_t r;
		r = '0;
		r.cmd = CMD_STREAM;
		r.sb = sb;
		plan_q.push_back(r);
	endfunction

	// ------------------------------------------------------------------
	// Drivers.
	// ------------------------------------------------------------------

	// Offers one item, waits for the handshake and records what it should
	// cause. Valid is left high so that a following item starts without a gap.
	task automatic send_item(logic [1:0] cmd, logic [7:0] idx, logic [15:0] pair, logic [7:0] sb,
			logic typed, logic has_run, run_t want);
		int n;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= cmd;
		dict_index  <= idx;
		dict_pair   <= pair;
		stream_byte <= sb;
		do @(posedge clk); while (!in_ready);
		if (cmd == CMD_IGNORED || (cmd == CMD_STREAM && xfer_idle))
			items_ignored++;
		else
			items_fed++;
		n = apply_item(cmd, idx, pair, sb);
		if (typed) begin
			if (has_run)
				runs_due.push_back(want);
		end else begin
			for (int i = 0; i < n; i++)
				runs_due.push_back(step_res[i]);
		end
	endtask

	task automatic feed(logic [1:0] cmd, logic [7:0] idx, logic [15:0] pair, logic [7:0] sb);
		send_item(cmd, idx, pair, sb, 1'b0, 1'b0, '0);
	endtask

	// Lets the block run empty: every expected run has arrived, and a further
	// wait covers an item that causes no run but is still in the pipeline.
	task automatic drain();
		in_valid <= 1'b0;
		while (runs_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes the bank register, then the length register; the block is idle.
	task automatic program_regs(logic [5:0] bank, logic [17:0] len);
		cfg_write <= 1'b1;
		cfg_index <= REG_DEST_BANK;
		cfg_data  <= CFG_DATA_W'(bank);
		@(posedge clk);
		cfg_index <= REG_LENGTH_CODE;
		cfg_data  <= len;
		@(posedge clk);
		cfg_write <= 1'b0;
		bank_reg = bank;
		len_reg = len;
		settings_used++;
	endtask

	// ------------------------------------------------------------------
	// Receiver: random bursts of back-pressure, one long hold-off on request
	// so that the block fills up and stalls its input, and none once the run
	// has entered its calm final part.
	// ------------------------------------------------------------------
	int rx_gap  = 0;
	int rx_hold = 0;

	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			rx_hold = HOLD_CYCLES;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			rx_gap = $urandom_range(1, 7) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Checker: each accepted run is compared with the oldest expectation.
	// ------------------------------------------------------------------
	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("MISMATCH %s: got 0x%0h, expected 0x%0h (run %0d)", what, got, want,
				runs_checked);
	endtask

	always @(posedge clk) begin
		run_t want;
		if (arst_n && out_valid && out_ready) begin
			runs_checked++;
			if (runs_due.size() == 0) begin
				report("write run with nothing expected, address", 32'(write_address), 32'd0);
			end else begin
				want = runs_due.pop_front();
				if (write_address !== want.addr)
					report("write_address", 32'(write_address), 32'(want.addr));
				if (write_value !== want.value)
					report("write_value", 32'(write_value), 32'(want.value));
				if (write_count !== want.count)
					report("write_count", 32'(write_count), 32'(want.count));
				if (item_last !== want.last)
					report("item_last", 32'(item_last), 32'(want.last));
				if (transfer_done !== want.done)
					report("transfer_done", 32'(transfer_done), 32'(want.done));
			end
		end
	end

	// Watchdog: ends the run when neither channel has moved for too long.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus.
	// ------------------------------------------------------------------
	initial begin
		logic [5:0]  bank;
		logic [17:0] len;
		logic [7:0]  b;
		int          budget;
		int          pick;

		for (int i = 0; i < 256; i++) begin
			pair_tab[i] = '0;
			pair_set[i] = 1'b0;
		end

		// Directed table. The first block runs with the top bank and the
		// longest length, so nothing ends the transfer early and every
		// address lies in the top bank of tile memory.
		plan_regs(6'd63, 18'h3FFFF);
		// A stream byte before any start is dropped, as is command 3.
		plan_quiet(CMD_STREAM, 8'h00, 16'h0000, 8'h5A);
		plan_quiet(CMD_IGNORED, 8'hFF, 16'hFFFF, 8'hFF);
		plan_quiet(CMD_LOAD, 8'hFF, 16'hFFFF, 8'h00);
		plan_quiet(CMD_LOAD, 8'h00, 16'h0000, 8'hFF);
		plan_quiet(CMD_LOAD, 8'h80, 16'hABAB, 8'h00);
		plan_quiet(CMD_START, 8'h00, 16'h0000, 8'h00);
		// Control byte 0110_0001: literal, two pairs, four literals, a pair.
		plan_quiet(CMD_STREAM, 8'h00, 16'h0000, 8'h61);
		plan_run(8'h07, 24'hFC0000, 8'h07, 8'd1, 1'b0);
		// The pair AB AB arms the repeat; the first byte of FF FF is then a
		// count of 255, which gives a run of count zero.
		plan_model(8'h80);
		plan_model(8'hFF);
		// A load in the middle of a transfer is legal and quiet.
		plan_quiet(CMD_LOAD, 8'h01, 16'h0102, 8'h00);
		// Two equal literals, then a literal count byte of 255.
		plan_model(8'h07);
		plan_model(8'h07);
		plan_model(8'hFF);
		plan_model(8'h00);
		plan_model(8'h01);
		plan_quiet(CMD_STREAM, 8'h00, 16'h0000, 8'hFF);
		plan_model(8'h00);
		// A start in the middle of a group makes the next byte a control byte.
		plan_quiet(CMD_START, 8'h00, 16'h0000, 8'h00);
		plan_quiet(CMD_STREAM, 8'h00, 16'h0000, 8'h00);
		plan_run(8'h00, 24'hFC0000, 8'h00, 8'd1, 1'b0);
		// Registers change under a live transfer: bank zero, four bytes long.
		// The repeat of 22 carries the offset past the end.
		plan_regs(6'd0, 18'd0);
		plan_run(8'h22, 24'h000001, 8'h22, 8'd1, 1'b0);
		plan_run(8'h22, 24'h000002, 8'h22, 8'd1, 1'b0);
		plan_run(8'h02, 24'h000003, 8'h22, 8'd3, 1'b1);
		plan_quiet(CMD_STREAM, 8'h00, 16'h0000, 8'h99);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < plan_q.size(); i++) begin
			if (plan_q[i].is_regs) begin
				drain();
				program_regs(plan_q[i].bank, plan_q[i].len);
			end else begin
				send_item(plan_q[i].cmd, plan_q[i].idx, plan_q[i].pair, plan_q[i].sb,
					plan_q[i].typed, plan_q[i].has_run, plan_q[i].run);
			end
		end

		// Random transfers. Each one gets fresh register values while the
		// block is idle; most start cleanly, some carry on a live transfer.
		// Lengths are kept short so that transfers end often, with the odd
		// zero and maximum length in between.
		while (items_fed < ITEM_GOAL) begin
			drain();
			case ($urandom_range(0, 5))
				0: bank = 6'd0;
				1: bank = 6'd63;
				default: bank = 6'($urandom);
			endcase
			case ($urandom_range(0, 7))
				0: len = 18'd0;
				1: len = 18'h3FFFF;
				default: len = 18'($urandom_range(1, 40));
			endcase
			program_regs(bank, len);
			if (xfer_idle || $urandom_range(0, 3) != 0)
				feed(CMD_START, 8'($urandom), 16'($urandom), 8'($urandom));
			budget = $urandom_range(8, 60);
			for (int k = 0; k < budget; k++) begin
				if (items_fed >= ITEM_GOAL)
					break;
				if (items_fed >= PRESSURE_AT)
					hold_req = 1'b1;
				if (items_fed >= ITEM_GOAL - CALM_ITEMS)
					calm = 1'b1;
				if (xfer_idle) begin
					// Sometimes poke the finished transfer with a stray byte.
					if ($urandom_range(0, 1) == 0)
						feed(CMD_STREAM, 8'($urandom), 16'($urandom), 8'($urandom));
					break;
				end
				pick = $urandom_range(0, 99);
				if (pick < 6) begin
					b = 8'($urandom);
					if ($urandom_range(0, 2) == 0)
						feed(CMD_LOAD, 8'($urandom), {b, b}, 8'($urandom));
					else
						feed(CMD_LOAD, 8'($urandom), 16'($urandom), 8'($urandom));
				end else if (pick < 9) begin
					feed(CMD_IGNORED, 8'($urandom), 16'($urandom), 8'($urandom));
				end else if (pick < 11) begin
					feed(CMD_START, 8'($urandom), 16'($urandom), 8'($urandom));
				end else begin
					feed(CMD_STREAM, 8'($urandom), 16'($urandom), pick_stream_byte());
				end
			end
		end

		// Wind down: let every expected run arrive, then watch a little longer
		// for anything the block should not have sent.
		in_valid <= 1'b0;
		while (runs_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run covered %0d decoding items and %0d dropped ones, %0d write runs,",
			items_fed, items_ignored, runs_checked);
		$display("%0d register settings and %0d loaded dictionary entries.",
			settings_used, loaded_q.size());
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
